// ===== rtl/core/rwm_pkg.sv =====
// ----------------------------------------------------------------------------
// rwm_pkg
// Types and constants shared by the ring window mean block.
// ----------------------------------------------------------------------------
package rwm_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int BACK_W    = 8;
  localparam int FRAC_W    = 8;
  localparam int WLEN_W    = 9;
  localparam int CNT_OUT_W = 9;

  localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd256;

  // register index, taken from byte address bit 2
  localparam logic REG_WINDOW_LEN = 1'b0;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [BACK_W-1:0]          back_whole;
    logic [FRAC_W-1:0]          back_fraction;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] window_mean;
    logic signed [SAMPLE_W-1:0] sample_back;
    logic [CNT_OUT_W-1:0]       filled_count;
  } out_item_t;

endpackage

// ===== rtl/core/rwm_ram.sv =====
// ----------------------------------------------------------------------------
// rwm_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rwm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rwm_div.sv =====
// ----------------------------------------------------------------------------
// rwm_div
// Bit-serial restoring divider, signed dividend by unsigned divisor,
// quotient truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwm_div #(
  parameter int DIVIDEND_W = 24,
  parameter int DIVISOR_W  = 9
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]         divisor,
  output logic                         busy,
  output logic signed [DIVIDEND_W-1:0] quotient
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] mag;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dsr;
  logic                  neg;
  logic [CW-1:0]         count;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] rem_next;
  logic               fits;

  always_comb begin
    trial    = {rem, mag[DIVIDEND_W-1]};
    fits     = trial >= {1'b0, dsr};
    rem_next = fits ? trial - {1'b0, dsr} : trial;
  end

  // quotient bits shift into mag as the dividend bits shift out
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CW'(DIVIDEND_W);
      mag   <= dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);
      neg   <= dividend[DIVIDEND_W-1];
      rem   <= '0;
      dsr   <= divisor;
    end else if (busy) begin
      mag   <= {mag[DIVIDEND_W-2:0], fits};
      rem   <= rem_next[DIVISOR_W-1:0];
      count <= count - CW'(1);
      if (count == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = neg ? -$signed(mag) : $signed(mag);

endmodule

// ===== rtl/core/ring_window_mean_with_lookback.sv =====
// ----------------------------------------------------------------------------
// ring_window_mean_with_lookback
// Ring of recent samples with running sum, fill count, window mean and
// interpolated lookback.
// ----------------------------------------------------------------------------
// an add item goes through the ring write, divider start and divide wait states to
// the result; a read item first reads two ring slots and interpolates, then divides
// a new item is taken only once the previous result has been handed on, since the
// bit-serial mean divider runs for each item; a read takes two passes over the single ring read port
// reset clears pointer, fill count and sum and sets window length to 256 at once;
// ring contents are left as they are, slots beyond the fill count read as zero
// ----------------------------------------------------------------------------
module ring_window_mean_with_lookback #(
  parameter int MAX_WINDOW = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rwm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rwm_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  import rwm_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_W + ADDR_W;
  localparam int IW     = ((CNT_W > BACK_W + 1) ? CNT_W : BACK_W + 1) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_WAIT,
    S_RD_B,
    S_INTERP,
    S_DIV_GO,
    S_DIV_WAIT
  } state_t;

  state_t                     state;
  in_item_t                   item;
  logic [WLEN_W-1:0]          window_len;
  logic [ADDR_W-1:0]          pos;
  logic [CNT_W-1:0]           fill;
  logic signed [SUM_W-1:0]    sum;
  logic                       a_ok;
  logic                       b_ok;
  logic signed [SAMPLE_W-1:0] a_val;
  logic signed [SAMPLE_W-1:0] back_val;

  logic [CNT_W-1:0]           len;
  logic [ADDR_W-1:0]          raddr;
  logic [SAMPLE_W-1:0]        rdata;
  logic                       ram_we;
  logic                       slot_ok;
  logic                       in_xfer;
  logic                       cfg_write;
  logic                       out_load;

  logic signed [SAMPLE_W-1:0]        rd_val;
  logic signed [SUM_W-1:0]           sum_next;
  logic [CNT_W-1:0]                  fill_next;
  logic [ADDR_W-1:0]                 pos_next;
  logic signed [SAMPLE_W:0]          diff;
  logic signed [FRAC_W:0]            frac_s;
  logic signed [SAMPLE_W+FRAC_W+1:0] prod;
  logic signed [SAMPLE_W+FRAC_W+2:0] num;

  logic                    div_start;
  logic                    div_busy;
  logic signed [SUM_W-1:0] quot;

  // slot that lies back places behind the newest, clamped to the oldest
  function automatic logic [ADDR_W-1:0] ring_idx(input logic [IW-1:0] back,
                                                 input logic [CNT_W-1:0] l,
                                                 input logic [ADDR_W-1:0] p);
    logic [IW-1:0] lx;
    logic [IW-1:0] b;
    logic [IW-1:0] s;
    lx = IW'(l);
    b  = (back >= lx) ? lx - IW'(1) : back;
    s  = IW'(p) + lx - IW'(1) - b;
    if (s >= lx) begin
      s = s - lx;
    end
    return s[ADDR_W-1:0];
  endfunction

  always_comb begin
    if (window_len == '0) begin
      len = CNT_W'(1);
    end else if (32'(window_len) > MAX_WINDOW) begin
      len = CNT_W'(MAX_WINDOW);
    end else begin
      len = CNT_W'(window_len);
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_WINDOW_LEN) ? 32'(window_len) : '0;
  assign div_start = (state == S_DIV_GO);
  assign ram_we    = (state == S_ADD_WAIT);
  assign out_load  = (state == S_DIV_WAIT) && !div_busy && (!out_valid || out_ready);

  always_comb begin
    case (state)
      S_IDLE: begin
        if (in_data.opcode == OP_ADD) begin
          raddr = pos;
        end else begin
          raddr = ring_idx(IW'(in_data.back_whole), len, pos);
        end
      end
      S_RD_B:  raddr = ring_idx(IW'(item.back_whole) + IW'(1), len, pos);
      default: raddr = pos;
    endcase
  end

  // slots at or past the fill count were never written since the last clear
  assign slot_ok = CNT_W'(raddr) < fill;

  rwm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos),
    .wdata (item.sample_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    rd_val    = $signed(rdata);
    sum_next  = sum
              - SUM_W'(a_ok ? rd_val : SAMPLE_W'(0))
              + SUM_W'(item.sample_in);
    fill_next = (fill < len) ? fill + CNT_W'(1) : fill;
    pos_next  = (CNT_W'(pos) + CNT_W'(1) == len) ? '0 : pos + ADDR_W'(1);
    diff      = (SAMPLE_W + 1)'(b_ok ? rd_val : SAMPLE_W'(0)) - (SAMPLE_W + 1)'(a_val);
    frac_s    = $signed({1'b0, item.back_fraction});
    prod      = diff * frac_s;
    num       = $signed({{3{a_val[SAMPLE_W-1]}}, a_val, {FRAC_W{1'b0}}})
              + (SAMPLE_W + FRAC_W + 3)'(prod);
  end

  rwm_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (fill),
    .busy     (div_busy),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      window_len <= WLEN_RESET;
      pos        <= '0;
      fill       <= '0;
      sum        <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write && paddr[2] == REG_WINDOW_LEN) begin
        window_len <= pwdata[WLEN_W-1:0];
        pos        <= '0;
        fill       <= '0;
        sum        <= '0;
      end else if (state == S_ADD_WAIT) begin
        sum  <= sum_next;
        fill <= fill_next;
        pos  <= pos_next;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            item <= in_data;
            a_ok <= slot_ok;
            if (in_data.opcode == OP_ADD) begin
              state <= S_ADD_WAIT;
            end else begin
              state <= S_RD_B;
            end
          end
        end
        S_ADD_WAIT: begin
          back_val <= '0;
          state    <= S_DIV_GO;
        end
        S_RD_B: begin
          a_val <= a_ok ? rd_val : '0;
          b_ok  <= slot_ok;
          state <= S_INTERP;
        end
        S_INTERP: begin
          // floor of the interpolated value is an arithmetic shift by the fraction width
          back_val <= num[SAMPLE_W+FRAC_W-1:FRAC_W];
          state    <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (out_load) begin
            out_data.window_mean     <= (fill == '0) ? '0 : SAMPLE_W'(quot);
            out_data.sample_back     <= back_val;
            out_data.filled_count    <= CNT_OUT_W'(fill);
            state                    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= len)
    else $error("fill count exceeds window length");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(pos) < len)
    else $error("write pointer outside window");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_DIV_WAIT)
    else $error("divider running outside its wait state");

  a_result_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DIV_WAIT)
    else $error("result raised without a finished divide");

endmodule
